>>> rtl/drtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtb_pkg
// types, widths and codes shared by the timer bank front, queue and back end
// ----------------------------------------------------------------------------
package drtb_pkg;

	localparam int SLOTS   = 10;
	localparam int TPS     = 128;

	localparam int CMD_W   = 3;
	localparam int SLOT_W  = 4;
	localparam int DELAY_W = 16;
	localparam int CNT_W   = 17;
	localparam int MASK_W  = 10;
	localparam int FLAG_W  = 3;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [FLAG_W-1:0] FLAG_ALLOC  = 3'h1;
	localparam logic [FLAG_W-1:0] FLAG_ARMED  = 3'h2;
	localparam logic [FLAG_W-1:0] FLAG_REPEAT = 3'h4;

	localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

	// ms to ticks: (ms * TPS) / 1000, done as >> 3 then / 125 by reciprocal
	localparam int MS_PER_S  = 1000;
	localparam int MS_PRE_SH = 3;
	localparam int MS_ODD    = MS_PER_S / (1 << MS_PRE_SH);
	localparam int ODD_LOG   = $clog2(MS_ODD) - 1;
	localparam int PROD_W    = DELAY_W + $clog2(TPS + 1);
	localparam int X_W       = PROD_W - MS_PRE_SH;
	localparam int RECIP_SH  = X_W;
	localparam int RECIP_W   = X_W - ODD_LOG;
	localparam int QW        = X_W - ODD_LOG;
	localparam int SAT_W     = (QW > DELAY_W) ? QW : DELAY_W;
	localparam longint unsigned RECIP_L = (64'd1 << RECIP_SH) / MS_ODD;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = 1;
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_SUB_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SEC_TICK = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESET    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DESTROY  = 3'd4;

	typedef logic [2:0] op_t;

	localparam op_t OP_SUB_TICK = 3'd0;
	localparam op_t OP_SEC_TICK = 3'd1;
	localparam op_t OP_CREATE   = 3'd2;
	localparam op_t OP_LOAD     = 3'd3;
	localparam op_t OP_FREE     = 3'd4;
	localparam op_t OP_NOP      = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [SLOT_W-1:0]  slot;
		logic [DELAY_W-1:0] delay_ms;
		logic               repeats;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] handle;
		logic              ok;
		logic [MASK_W-1:0] expired_mask;
		logic              prescale_on;
	} rsp_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic              repeats;
		logic [PROD_W-1:0] prod;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> rtl/drtb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtb_front
// takes requests, classifies the command, checks the slot range and forms
// the raw millisecond-times-rate product before queueing the job
// ----------------------------------------------------------------------------
module drtb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  drtb_pkg::req_t      req_data,
	input  drtb_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output drtb_pkg::job_t      job
);
	import drtb_pkg::*;

	logic valid_s1;
	job_t job_s1;
	op_t  op_d;
	logic in_range;

	assign in_range = {1'b0, req_data.slot} < (SLOT_W + 1)'(SLOTS);

	always_comb begin
		unique case (req_data.cmd)
			CMD_SUB_TICK: op_d = OP_SUB_TICK;
			CMD_SEC_TICK: op_d = OP_SEC_TICK;
			CMD_CREATE:   op_d = OP_CREATE;
			CMD_RESET:    op_d = in_range ? OP_LOAD : OP_NOP;
			CMD_DESTROY:  op_d = in_range ? OP_FREE : OP_NOP;
			default:      op_d = OP_NOP;
		endcase
	end

	assign req_stall = valid_s1 && fifo_stat.full;
	assign push      = valid_s1 && !fifo_stat.full;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			job_s1.op      <= op_d;
			job_s1.idx     <= IDX_W'(req_data.slot);
			job_s1.repeats <= req_data.repeats;
			job_s1.prod    <= PROD_W'(req_data.delay_ms) * PROD_W'(TPS);
		end
	end

endmodule

>>> rtl/drtb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtb_fifo
// short job queue between front and back end
// ----------------------------------------------------------------------------
module drtb_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  drtb_pkg::job_t       push_job,
	input  logic                 pop,
	output drtb_pkg::job_t       head,
	output drtb_pkg::fifo_stat_t stat
);
	import drtb_pkg::*;

	job_t              mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == FCNT_W'(FIFO_DEPTH);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("job popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FCNT_W'(FIFO_DEPTH)) else $error("queue count out of range");
`endif

endmodule

>>> rtl/drtb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drtb_back
// executes queued jobs on the slot store: tick walk, create, load, free,
// with a registered result stage toward the output
// ----------------------------------------------------------------------------
module drtb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  drtb_pkg::job_t       head,
	input  drtb_pkg::fifo_stat_t fifo_stat,
	output logic                 pop,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output drtb_pkg::rsp_t       rsp_data
);
	import drtb_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHK   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_CORR  = 3'd3;
	localparam logic [2:0] ST_APPLY = 3'd4;
	localparam logic [2:0] ST_WALK  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [FLAG_W-1:0]  flags_q [SLOTS];
	logic [DELAY_W-1:0] delay_q [SLOTS];
	logic [CNT_W-1:0]   cnt_q   [SLOTS];
	logic               prescale_q;
	logic               out_valid_q;
	rsp_t               out_q;

	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic               rep_q;
	logic [X_W-1:0]     x_q;
	logic [QW-1:0]      qe_q;
	logic [QW-1:0]      t_q;
	logic [MASK_W-1:0]  mask_q;
	logic               want_q;
	logic [SLOT_W-1:0]  handle_q;
	logic               ok_q;

	logic [FLAG_W-1:0]  acc_flags;
	logic [DELAY_W-1:0] acc_delay;
	logic [CNT_W-1:0]   acc_cnt;
	logic               is_sub;
	logic               is_tick;
	logic               stepping;
	logic [CNT_W-1:0]   step;
	logic [CNT_W:0]     diff;
	logic               expire;
	logic               low_left;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	logic [X_W+RECIP_W-1:0] recip_prod;
	logic [X_W-1:0]     rem;
	logic [DELAY_W-1:0] t_sat;
	logic [FLAG_W-1:0]  load_flags;
	logic               fire;
	logic               head_tick;

	function automatic logic rep_q_of(input logic [FLAG_W-1:0] f);
		return (f & FLAG_REPEAT) != '0;
	endfunction

	assign acc_flags = flags_q[idx_q];
	assign acc_delay = delay_q[idx_q];
	assign acc_cnt   = cnt_q[idx_q];

	assign is_sub   = op_q == OP_SUB_TICK;
	assign is_tick  = (op_q == OP_SUB_TICK) || (op_q == OP_SEC_TICK);
	assign stepping = ((acc_flags & FLAG_ALLOC) != '0) && ((acc_flags & FLAG_ARMED) != '0)
		&& ((acc_delay >= DELAY_W'(TPS)) != is_sub);
	assign step     = is_sub ? CNT_W'(1) : CNT_W'(TPS);
	assign diff     = {1'b0, acc_cnt} - {1'b0, step};
	assign expire   = diff[CNT_W] || (diff == '0);
	assign low_left = diff[CNT_W-1:0] < CNT_W'(TPS);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if ((flags_q[i] & FLAG_ALLOC) == '0) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign recip_prod = (X_W + RECIP_W)'(x_q) * (X_W + RECIP_W)'(RECIP);
	assign rem        = x_q - X_W'(qe_q) * X_W'(MS_ODD);
	assign t_sat      = (SAT_W'(t_q) > SAT_W'(DELAY_MAX)) ? DELAY_MAX : DELAY_W'(t_q);

	always_comb begin
		load_flags = acc_flags;
		if (op_q == OP_CREATE) begin
			load_flags = load_flags | FLAG_ALLOC;
		end
		if (rep_q) begin
			load_flags = load_flags | FLAG_REPEAT;
		end else begin
			load_flags = load_flags & ~FLAG_REPEAT;
		end
		if (t_sat != '0) begin
			load_flags = load_flags | FLAG_ARMED;
		end
	end

	assign pop       = (state_q == ST_IDLE) && !fifo_stat.empty;
	assign head_tick = (head.op == OP_SUB_TICK) || (head.op == OP_SEC_TICK);
	assign fire      = (state_q == ST_DONE) && (!out_valid_q || !rsp_stall);
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			prescale_q  <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				flags_q[i] <= '0;
			end
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!fifo_stat.empty) begin
						if (head_tick) begin
							state_q <= ST_WALK;
						end else if (head.op == OP_CREATE) begin
							state_q <= free_found ? ST_DIV : ST_DONE;
						end else if (head.op == OP_LOAD || head.op == OP_FREE) begin
							state_q <= ST_CHK;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CHK: begin
					if ((acc_flags & FLAG_ALLOC) == '0) begin
						state_q <= ST_DONE;
					end else if (op_q == OP_FREE) begin
						flags_q[idx_q] <= '0;
						state_q        <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					flags_q[idx_q] <= load_flags;
					if (t_sat != '0 && t_sat < DELAY_W'(TPS)) begin
						prescale_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_WALK: begin
					if (stepping && expire && !rep_q_of(acc_flags)) begin
						flags_q[idx_q] <= acc_flags & ~FLAG_ARMED;
					end
					if (idx_q == IDX_W'(SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (fire) begin
						if (is_tick) begin
							prescale_q <= want_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!fifo_stat.empty) begin
					op_q     <= head.op;
					rep_q    <= head.repeats;
					x_q      <= head.prod[PROD_W-1:MS_PRE_SH];
					mask_q   <= '0;
					want_q   <= 1'b0;
					if (head.op == OP_CREATE) begin
						idx_q    <= free_idx;
						ok_q     <= free_found;
						handle_q <= free_found ? SLOT_W'(free_idx) : '0;
					end else begin
						idx_q    <= head_tick ? '0 : head.idx;
						ok_q     <= head_tick;
						handle_q <= '0;
					end
				end
			end
			ST_CHK: begin
				ok_q <= (acc_flags & FLAG_ALLOC) != '0;
			end
			ST_DIV: begin
				qe_q <= QW'(recip_prod >> RECIP_SH);
			end
			ST_CORR: begin
				t_q <= (rem >= X_W'(MS_ODD)) ? qe_q + 1'b1 : qe_q;
			end
			ST_APPLY: begin
				delay_q[idx_q] <= t_sat;
				cnt_q[idx_q]   <= CNT_W'(t_sat);
			end
			ST_WALK: begin
				if (stepping) begin
					if (expire) begin
						cnt_q[idx_q] <= rep_q_of(acc_flags) ? CNT_W'(acc_delay) : '0;
						mask_q       <= mask_q | (MASK_W'(1) << idx_q);
					end else begin
						cnt_q[idx_q] <= diff[CNT_W-1:0];
						want_q       <= want_q | low_left;
					end
				end
				if (idx_q != IDX_W'(SLOTS - 1)) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (fire) begin
					out_q.handle       <= handle_q;
					out_q.ok           <= ok_q;
					out_q.expired_mask <= mask_q;
					out_q.prescale_on  <= is_tick ? want_q : prescale_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_mask_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.expired_mask != '0) |-> out_q.ok)
		else $error("expiry reported on a failed request");
	a_handle_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.handle != '0) |-> out_q.ok)
		else $error("handle reported on a failed request");
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (idx_q <= IDX_W'(SLOTS - 1)))
		else $error("slot walk out of range");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != ST_IDLE))
		else $error("job popped without being started");
`endif

endmodule

>>> rtl/dual_rate_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_rate_timer_bank
// bank of countdown timers with sub-second and second ticks
// a tick walks the slot store one slot per cycle; the back end finishes one job
//   before it starts the next, while new requests wait in the job queue
// reset: all slots free, prescale request cleared, no clearing pass
// ----------------------------------------------------------------------------
module dual_rate_timer_bank (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  drtb_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output drtb_pkg::rsp_t rsp_data
);
	import drtb_pkg::*;

	logic       push;
	logic       pop;
	job_t       push_job;
	job_t       head;
	fifo_stat_t fifo_stat;

	drtb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.fifo_stat (fifo_stat),
		.push      (push),
		.job       (push_job)
	);

	drtb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (fifo_stat)
	);

	drtb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

>>> dv/dual_rate_timer_bank_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_rate_timer_bank_test
// self-checking test of the timer bank: a directed opening covers empty and
// full banks, free and out-of-range slots, unknown commands, zero and longest
// delays and both tick rates; random request streams with random idling on
// both sides follow, and every response is checked against a predicted bank
// ----------------------------------------------------------------------------
module dual_rate_timer_bank_test;
	import drtb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
	localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;
	localparam int RANDOM_REQUESTS = 1625;

	class timer_scoreboard;
		logic [FLAG_W-1:0]  flags[SLOTS];
		logic [DELAY_W-1:0] reload[SLOTS];
		logic [CNT_W-1:0]   remain[SLOTS];
		logic               tick_req;
		rsp_t               pending_rsp[$];
		int                 failures;
		int                 requests;
		int                 responses;
		int                 expiries;
		int                 grants;
		int                 refusals;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				flags[i]  = '0;
				reload[i] = '0;
				remain[i] = '0;
			end
			tick_req  = 1'b0;
			failures  = 0;
			requests  = 0;
			responses = 0;
			expiries  = 0;
			grants    = 0;
			refusals  = 0;
		endfunction

		function void load_timer(int s, logic [DELAY_W-1:0] ms, logic rep);
			int unsigned ticks;
			ticks = (32'(ms) * TPS) / MS_PER_S;
			if (ticks > DELAY_MAX)
				ticks = DELAY_MAX;
			reload[s] = ticks[DELAY_W-1:0];
			remain[s] = CNT_W'(ticks);
			if (rep)
				flags[s] = flags[s] | FLAG_REPEAT;
			else
				flags[s] = flags[s] & ~FLAG_REPEAT;
			if (ticks > 0) begin
				flags[s] = flags[s] | FLAG_ARMED;
				if (ticks < TPS)
					tick_req = 1'b1;
			end
		endfunction

		function logic [MASK_W-1:0] run_tick(bit sub);
			logic [MASK_W-1:0] mask;
			bit                want;
			bit                long_timer;
			int                dec;
			int                c;
			mask = '0;
			want = 1'b0;
			dec  = sub ? 1 : TPS;
			for (int i = 0; i < SLOTS; i++) begin
				if ((flags[i] & FLAG_ALLOC) == '0 || (flags[i] & FLAG_ARMED) == '0)
					continue;
				long_timer = (reload[i] >= TPS);
				if (long_timer == sub)
					continue;
				c = int'(remain[i]) - dec;
				if (c <= 0) begin
					if ((flags[i] & FLAG_REPEAT) != '0)
						remain[i] = CNT_W'(reload[i]);
					else begin
						remain[i] = '0;
						flags[i]  = flags[i] & ~FLAG_ARMED;
					end
					if (i < MASK_W)
						mask[i] = 1'b1;
				end else begin
					remain[i] = CNT_W'(c);
					if (c < TPS)
						want = 1'b1;
				end
			end
			tick_req = want;
			return mask;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			e = '0;
			requests++;
			case (r.cmd)
				CMD_SUB_TICK, CMD_SEC_TICK: begin
					e.expired_mask = run_tick(r.cmd == CMD_SUB_TICK);
					e.ok           = 1'b1;
					expiries += $countones(e.expired_mask);
				end
				CMD_CREATE: begin
					for (int i = 0; i < SLOTS; i++) begin
						if ((flags[i] & FLAG_ALLOC) == '0) begin
							flags[i] = flags[i] | FLAG_ALLOC;
							load_timer(i, r.delay_ms, r.repeats);
							e.handle = SLOT_W'(i);
							e.ok     = 1'b1;
							break;
						end
					end
					if (e.ok)
						grants++;
					else
						refusals++;
				end
				CMD_RESET, CMD_DESTROY: begin
					if (r.slot < SLOTS) begin
						if ((flags[r.slot] & FLAG_ALLOC) != '0) begin
							if (r.cmd == CMD_RESET)
								load_timer(r.slot, r.delay_ms, r.repeats);
							else
								flags[r.slot] = '0;
							e.ok = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			e.prescale_on = tick_req;
			pending_rsp.push_back(e);
		endfunction

		function void report(string field, int unsigned exp_val, int unsigned act_val);
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val,
				act_val);
			failures++;
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with no request outstanding, expected none, actual %p",
					$time, a);
				failures++;
				return;
			end
			e = pending_rsp.pop_front();
			responses++;
			if (a.handle !== e.handle)
				report("handle", e.handle, a.handle);
			if (a.ok !== e.ok)
				report("ok", e.ok, a.ok);
			if (a.expired_mask !== e.expired_mask)
				report("expired_mask", e.expired_mask, a.expired_mask);
			if (a.prescale_on !== e.prescale_on)
				report("prescale_on", e.prescale_on, a.prescale_on);
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;
	bit   calm      = 1'b0;

	timer_scoreboard sb;

	dual_rate_timer_bank i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 16);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp_data);
	end

	function automatic req_t make_req(logic [CMD_W-1:0] cmd, int unsigned slot,
		int unsigned ms, int unsigned rep);
		req_t r;
		r.cmd      = cmd;
		r.slot     = SLOT_W'(slot);
		r.delay_ms = DELAY_W'(ms);
		r.repeats  = 1'(rep);
		return r;
	endfunction

	task automatic send_request(req_t r);
		if (!calm && $urandom_range(99) < 16) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		#2_000_000;
		$display("dual_rate_timer_bank regression: fail");
		$finish;
	end

	initial begin
		req_t        r;
		int unsigned pick;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty bank, free and out-of-range slots, unknown commands
		send_request(make_req(CMD_SUB_TICK, 0, 0, 0));
		send_request(make_req(CMD_SEC_TICK, 15, 16'hFFFF, 1));
		send_request(make_req(CMD_RESET, 0, 100, 1));
		send_request(make_req(CMD_DESTROY, 15, 0, 0));
		send_request(make_req(CMD_FIRST_UNUSED, 15, 16'hFFFF, 1));
		send_request(make_req(CMD_FIRST_UNUSED + 3'd1, 9, 16'h5555, 0));
		send_request(make_req(CMD_LAST_UNUSED, 10, 16'hAAAA, 1));
		// zero delay, longest delay, one tick, exactly one second
		send_request(make_req(CMD_CREATE, 0, 0, 0));
		send_request(make_req(CMD_CREATE, 0, 16'hFFFF, 1));
		send_request(make_req(CMD_CREATE, 0, 8, 1));
		send_request(make_req(CMD_CREATE, 0, 1000, 0));
		// zero delay on an armed timer keeps it armed
		send_request(make_req(CMD_RESET, 2, 0, 1));
		send_request(make_req(CMD_SUB_TICK, 0, 0, 0));
		send_request(make_req(CMD_SEC_TICK, 0, 0, 0));
		// fill the bank, then one create too many
		for (int i = 0; i < SLOTS - 3; i++)
			send_request(make_req(CMD_CREATE, 0, 16 * (i + 1), i % 2));
		send_request(make_req(CMD_RESET, 12, 50, 1));
		send_request(make_req(CMD_DESTROY, SLOTS - 1, 0, 0));
		send_request(make_req(CMD_DESTROY, SLOTS - 1, 0, 0));
		send_request(make_req(CMD_SUB_TICK, 0, 0, 0));

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == 600)
				calm <= 1'b1;
			if (n == 900)
				calm <= 1'b0;
			if (n == 1100)
				drain();
			pick = $urandom_range(99);
			if (pick < 40)
				r.cmd = CMD_SUB_TICK;
			else if (pick < 52)
				r.cmd = CMD_SEC_TICK;
			else if (pick < 70)
				r.cmd = CMD_CREATE;
			else if (pick < 84)
				r.cmd = CMD_RESET;
			else if (pick < 97)
				r.cmd = CMD_DESTROY;
			else
				r.cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
			r.slot = ($urandom_range(99) < 80) ? SLOT_W'($urandom_range(SLOTS - 1))
				: SLOT_W'($urandom_range(15));
			pick = $urandom_range(99);
			if (pick < 10)
				r.delay_ms = '0;
			else if (pick < 55)
				r.delay_ms = DELAY_W'($urandom_range(1, 120));
			else if (pick < 85)
				r.delay_ms = DELAY_W'($urandom_range(1000, 4000));
			else
				r.delay_ms = DELAY_W'($urandom_range(16'hFFFF));
			r.repeats = 1'($urandom_range(1));
			send_request(r);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("%0d requests, %0d responses checked, %0d expiries, %0d creates granted",
			sb.requests, sb.responses, sb.expiries, sb.grants);
		$display("%0d creates refused on a full bank", sb.refusals);
		if (sb.failures == 0 && sb.pending_rsp.size() == 0)
			$display("dual_rate_timer_bank regression: pass");
		else
			$display("dual_rate_timer_bank regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/drtb_pkg.sv
rtl/drtb_front.sv
rtl/drtb_fifo.sv
rtl/drtb_back.sv
rtl/dual_rate_timer_bank.sv
dv/dual_rate_timer_bank_test.sv
